[design/segment_clip_against_planes_defines.svh]
// Assertion macros shared by the segment clipper checker.
// No dependencies.
`ifndef SEGMENT_CLIP_AGAINST_PLANES_DEFINES_SVH
`define SEGMENT_CLIP_AGAINST_PLANES_DEFINES_SVH
// Implication checked on every clock, off during reset.
`define SCP_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("scp check failed");
// Next-cycle implication.
`define SCP_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("scp check failed");
`endif

[design/scp_pkg.sv]
// Shared types and constants for the segment clipper.
// No dependencies.
`default_nettype none
package scp_pkg;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CLIP = 1'b1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    vec_t n;
    vec_t q;
  } plane_t;

  // Segment token travelling along the cell chain.
  typedef struct packed {
    logic busy;
    logic kept;
    logic last;
    vec_t a;
    vec_t b;
  } seg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

[design/scp_div.sv]
// Serial signed divider, one quotient bit per cycle, quotient truncated.
// Depends on nothing but its ports.
`default_nettype none
module scp_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] num,
  input  wire logic signed [63:0] den,
  output logic                    done,
  output logic signed [63:0]      quo
);
  logic [63:0] rem_r, rem_nxt, q_r, q_nxt, d_r;
  logic [6:0]  cnt_r;
  logic        run_r, neg_r;
  logic [64:0] trial;

  always_comb begin
    trial   = {rem_r, q_r[63]} - {1'b0, d_r};
    rem_nxt = trial[64] ? {rem_r[62:0], q_r[63]} : trial[63:0];
    q_nxt   = {q_r[62:0], ~trial[64]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 7'd64;
        rem_r <= '0;
        q_r   <= num[63] ? -num : num;
        d_r   <= den[63] ? -den : den;
        neg_r <= num[63] ^ den[63];
      end else if (run_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule
`default_nettype wire

[design/scp_cell.sv]
// One clip cell: holds one plane and clips the passing segment against it.
// Depends on scp_pkg and scp_div.
`default_nettype none
module scp_cell #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire scp_pkg::plane_t    plane_in,
  input  wire logic               enable,
  input  wire logic               start,
  input  wire scp_pkg::seg_t      seg_in,
  output scp_pkg::seg_t           seg_out,
  output logic                    done
);
  localparam logic signed [63:0] EPS = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] INSIDE_EPS = (EPS + 64'sd500) / 64'sd1000;
  localparam logic signed [63:0] T_LIMIT = (64'sd1 <<< (62 - FRAC_BITS)) - 64'sd1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DIFF = 6'b000010, S_MUL = 6'b000100,
    S_SUM  = 6'b001000, S_DIV  = 6'b010000, S_APP = 6'b100000
  } st_t;

  scp_pkg::plane_t pl_r;
  scp_pkg::seg_t   s_r;
  st_t             st_r;
  logic [1:0]      k_r;
  logic signed [31:0] da3_r [3], db3_r [3], dir3_r [3], nv [3], qv [3], av [3], bv [3];
  logic signed [63:0] pa_r [3], pb_r [3], pd_r [3];
  logic signed [63:0] da_r, db_r, den_r;
  logic signed [31:0] t_r;
  logic signed [31:0] pt_r [3];
  logic ina_r;
  logic dstart;
  logic ddone;
  logic signed [63:0] dquo, dnum, dden;

  assign nv = '{pl_r.n.x, pl_r.n.y, pl_r.n.z};
  assign qv = '{pl_r.q.x, pl_r.q.y, pl_r.q.z};
  assign av = '{s_r.a.x, s_r.a.y, s_r.a.z};
  assign bv = '{s_r.b.x, s_r.b.y, s_r.b.z};

  function automatic logic signed [63:0] lim(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > T_LIMIT) r = T_LIMIT;
    else if (v < -T_LIMIT) r = -T_LIMIT;
    else r = v;
    return r;
  endfunction

  assign dnum = -(lim(da_r) <<< FRAC_BITS);
  assign dden = lim(den_r);

  scp_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(dden),
                 .done(ddone), .quo(dquo));

  logic signed [31:0] tq;
  logic signed [63:0] prod;
  logic signed [31:0] dirk, ak;
  always_comb begin
    tq   = scp_pkg::sat32(66'(dquo));
    dirk = dir3_r[k_r];
    ak   = av[k_r];
    prod = 64'(t_r) * 64'(dirk);
  end

  always_ff @(posedge clk) begin
    if (load) pl_r <= plane_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done   <= 1'b0;
      dstart <= 1'b0;
    end else begin
      done   <= 1'b0;
      dstart <= 1'b0;
      unique case (st_r)
        S_IDLE: if (start) begin
          s_r <= seg_in;
          if (enable && seg_in.kept) st_r <= S_DIFF;
          else done <= 1'b1;
        end
        S_DIFF: begin
          for (int k = 0; k < 3; k++) begin
            da3_r[k]  <= scp_pkg::sat32(66'(av[k]) - 66'(qv[k]));
            db3_r[k]  <= scp_pkg::sat32(66'(bv[k]) - 66'(qv[k]));
            dir3_r[k] <= scp_pkg::sat32(66'(bv[k]) - 66'(av[k]));
          end
          st_r <= S_MUL;
        end
        S_MUL: begin
          for (int k = 0; k < 3; k++) begin
            pa_r[k] <= (64'(nv[k]) * 64'(da3_r[k])) >>> FRAC_BITS;
            pb_r[k] <= (64'(nv[k]) * 64'(db3_r[k])) >>> FRAC_BITS;
            pd_r[k] <= (64'(nv[k]) * 64'(dir3_r[k])) >>> FRAC_BITS;
          end
          st_r <= S_SUM;
        end
        S_SUM: begin
          da_r  <= pa_r[0] + pa_r[1] + pa_r[2];
          db_r  <= pb_r[0] + pb_r[1] + pb_r[2];
          den_r <= pd_r[0] + pd_r[1] + pd_r[2];
          st_r  <= S_DIV;
          k_r   <= 2'd3;
        end
        S_DIV: begin
          if (k_r == 2'd3) begin
            ina_r <= da_r <= INSIDE_EPS;
            if (da_r <= INSIDE_EPS && db_r <= INSIDE_EPS) begin
              st_r <= S_IDLE; done <= 1'b1;
            end else if (da_r > INSIDE_EPS && db_r > INSIDE_EPS) begin
              s_r.kept <= 1'b0; st_r <= S_IDLE; done <= 1'b1;
            end else if (den_r == 64'sd0) begin
              if (db_r > INSIDE_EPS) s_r.b <= s_r.a;
              else s_r.a <= s_r.a;
              st_r <= S_IDLE; done <= 1'b1;
            end else begin
              dstart <= 1'b1; k_r <= 2'd2;
            end
          end else if (ddone) begin
            t_r <= tq; k_r <= 2'd0; st_r <= S_APP;
          end
        end
        S_APP: begin
          pt_r[k_r] <= scp_pkg::sat32(66'(ak) + 66'(prod >>> FRAC_BITS));
          if (k_r == 2'd2) begin
            if (ina_r) s_r.b <= '{pt_r[0], pt_r[1],
                          scp_pkg::sat32(66'(ak) + 66'(prod >>> FRAC_BITS))};
            else s_r.a <= '{pt_r[0], pt_r[1],
                          scp_pkg::sat32(66'(ak) + 66'(prod >>> FRAC_BITS))};
            st_r <= S_IDLE; done <= 1'b1;
          end else k_r <= k_r + 2'd1;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign seg_out = s_r;
endmodule
`default_nettype wire

[design/segment_clip_against_planes.sv]
// Top level: chain of plane cells, output register, survivor flag.
// Depends on scp_pkg and scp_cell.
//
//  channel | dir | beat
//  in_     | in  | command, plane slot, two vectors, last flag
//  out_    | out | kept, clipped segment, last echo, contact flag
//  cfg_    | in  | plane_count
// A load writes the addressed plane slot. A clip walks the chain cell by cell: a
// skipped cell passes it on, an active cell runs its difference, multiply, sum and
// decision states, and a cutting cell runs the divider and applies the cut point.
// Reset clears control state and sets plane_count to 6; plane slots stay unwritten.
// A stalled output holds its beat; the next clip still runs and its result waits
// in the last cell, input closed, until the output register frees.
`default_nettype none
module segment_clip_against_planes #(
  parameter int MAX_PLANES = 8,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_command,
  input  wire logic [2:0]         in_plane_index,
  input  wire logic signed [31:0] in_ax,
  input  wire logic signed [31:0] in_ay,
  input  wire logic signed [31:0] in_az,
  input  wire logic signed [31:0] in_bx,
  input  wire logic signed [31:0] in_by,
  input  wire logic signed [31:0] in_bz,
  input  wire logic               in_last_edge,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_kept,
  output logic signed [31:0]      out_ax,
  output logic signed [31:0]      out_ay,
  output logic signed [31:0]      out_az,
  output logic signed [31:0]      out_bx,
  output logic signed [31:0]      out_by,
  output logic signed [31:0]      out_bz,
  output logic                    out_last_out,
  output logic                    out_contact_found,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_plane_count
);
  scp_pkg::seg_t seg [MAX_PLANES+1];
  logic          go  [MAX_PLANES+1];
  logic [3:0]    cnt_r;
  logic          busy_r, surv_r, ovalid_r, pend_r;
  scp_pkg::seg_t res_r, res_nxt;
  logic          contact_r;
  logic          acc, move;
  logic [5:0]    eff;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r;
  assign acc       = in_valid && in_ready;
  assign eff       = (6'(cnt_r) > 6'(MAX_PLANES)) ? 6'(MAX_PLANES) : 6'(cnt_r);
  // advance the finished segment once the output register is free
  assign move      = (go[MAX_PLANES] || pend_r) && (!ovalid_r || out_ready);

  assign seg[0] = '{busy: 1'b1, kept: 1'b1, last: in_last_edge,
                    a: '{in_ax, in_ay, in_az}, b: '{in_bx, in_by, in_bz}};
  assign go[0]  = acc && in_command == scp_pkg::CMD_CLIP;

  for (genvar i = 0; i < MAX_PLANES; i++) begin : g_cell
    scp_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk, .rst_n,
      .load(acc && in_command == scp_pkg::CMD_LOAD && 32'(in_plane_index) == i),
      .plane_in('{n: '{in_ax, in_ay, in_az}, q: '{in_bx, in_by, in_bz}}),
      .enable(32'(eff) > i), .start(go[i]), .seg_in(seg[i]),
      .seg_out(seg[i+1]), .done(go[i+1]));
  end

  always_comb begin
    res_nxt = seg[MAX_PLANES];
    // drop endpoints of a rejected segment
    if (!seg[MAX_PLANES].kept) begin
      res_nxt.a = '0;
      res_nxt.b = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 4'd6;
      busy_r   <= 1'b0;
      surv_r   <= 1'b0;
      ovalid_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      if (cfg_valid) cnt_r <= cfg_plane_count;
      if (go[0]) busy_r <= 1'b1;
      else if (move) busy_r <= 1'b0;
      if (move) pend_r <= 1'b0;
      else if (go[MAX_PLANES]) pend_r <= 1'b1;
      if (move) ovalid_r <= 1'b1;
      else if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      if (move) begin
        res_r     <= res_nxt;
        contact_r <= seg[MAX_PLANES].last && (surv_r || seg[MAX_PLANES].kept);
        if (seg[MAX_PLANES].last) surv_r <= 1'b0;
        else if (seg[MAX_PLANES].kept) surv_r <= 1'b1;
      end
    end
  end

  assign out_valid         = ovalid_r;
  assign out_kept          = res_r.kept;
  assign out_ax            = res_r.a.x;
  assign out_ay            = res_r.a.y;
  assign out_az            = res_r.a.z;
  assign out_bx            = res_r.b.x;
  assign out_by            = res_r.b.y;
  assign out_bz            = res_r.b.z;
  assign out_last_out      = res_r.last && res_r.busy;
  assign out_contact_found = contact_r;
endmodule
`default_nettype wire

[design/scp_checker.sv]
// Port-level checks for the segment clipper, bound to the top level.
// Depends on segment_clip_against_planes_defines.svh.
`default_nettype none
`include "segment_clip_against_planes_defines.svh"
module scp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_kept,
  input wire logic out_last_out,
  input wire logic out_contact_found,
  input wire logic signed [31:0] out_ax
);
  `SCP_ASSERT_IMP(a_contact_last, clk, rst_n, out_valid && out_contact_found, out_last_out)
  `SCP_ASSERT_IMP(a_drop_zero, clk, rst_n, out_valid && !out_kept, out_ax == 32'sd0)
  `SCP_ASSERT_IMP(a_kept_contact, clk, rst_n, out_valid && out_kept && out_last_out, out_contact_found)
  `SCP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SCP_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)
endmodule
bind segment_clip_against_planes scp_checker u_scp_checker (.*);
`default_nettype wire
